FILE: design/jap_pkg.sv
// Shared types and constants for the joint angle P controller.
// No dependencies; every other design file refers to this package by scoped names.
package jap_pkg;

    localparam int NUM_JOINTS = 6;

    // fixed field widths
    localparam int ANGLE_W    = 19;
    localparam int VEL_W      = 21;
    localparam int OFFSET_W   = 18;
    localparam int TOL_W      = 16;
    localparam int GAIN_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ABORT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd3;

    // configuration reset values
    localparam logic signed [OFFSET_W-1:0] OFFSET_RST = 18'sd0;
    localparam logic [TOL_W-1:0]           GOAL_RST   = 16'd256;
    localparam logic [TOL_W-1:0]           ABORT_RST  = 16'd10240;
    localparam logic [GAIN_W-1:0]          GAIN_RST   = 4'd2;

    // lane pipeline stages
    localparam int NUM_STAGES = 5;
    localparam int ST_MAP  = 0;  // physical map, bias to non-negative
    localparam int ST_MUL  = 1;  // reciprocal multiply
    localparam int ST_WRAP = 2;  // remainder, wrap to [-180,180)
    localparam int ST_ERR  = 3;  // shortest error, tolerance compares
    localparam int ST_VEL  = 4;  // gain multiply

    // DH to physical target map, one bit per joint
    localparam logic [NUM_JOINTS-1:0] JNT_ADD_TARGET   = 6'b000010;
    localparam logic [NUM_JOINTS-1:0] JNT_USE_OFFSET   = 6'b100010;
    localparam logic [NUM_JOINTS-1:0] JNT_QUARTER_BASE = 6'b000100;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } pipe_ctrl_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel;
        logic                    move;
        logic                    over;
    } lane_res_t;

endpackage

FILE: design/jap_if.sv
// Valid/ready channel interfaces for the controller's input and result items.
// Depends on jap_pkg for field widths.
interface jap_in_if;
    logic valid;
    logic ready;
    logic signed [jap_pkg::ANGLE_W-1:0] target_one;
    logic signed [jap_pkg::ANGLE_W-1:0] target_two;
    logic signed [jap_pkg::ANGLE_W-1:0] target_three;
    logic signed [jap_pkg::ANGLE_W-1:0] target_four;
    logic signed [jap_pkg::ANGLE_W-1:0] target_five;
    logic signed [jap_pkg::ANGLE_W-1:0] target_six;
    logic signed [jap_pkg::ANGLE_W-1:0] measured_one;
    logic signed [jap_pkg::ANGLE_W-1:0] measured_two;
    logic signed [jap_pkg::ANGLE_W-1:0] measured_three;
    logic signed [jap_pkg::ANGLE_W-1:0] measured_four;
    logic signed [jap_pkg::ANGLE_W-1:0] measured_five;
    logic signed [jap_pkg::ANGLE_W-1:0] measured_six;

    modport source (
        output valid, target_one, target_two, target_three, target_four, target_five,
               target_six, measured_one, measured_two, measured_three, measured_four,
               measured_five, measured_six,
        input  ready
    );
    modport sink (
        input  valid, target_one, target_two, target_three, target_four, target_five,
               target_six, measured_one, measured_two, measured_three, measured_four,
               measured_five, measured_six,
        output ready
    );
endinterface

interface jap_out_if;
    logic valid;
    logic ready;
    logic signed [jap_pkg::VEL_W-1:0] velocity_one;
    logic signed [jap_pkg::VEL_W-1:0] velocity_two;
    logic signed [jap_pkg::VEL_W-1:0] velocity_three;
    logic signed [jap_pkg::VEL_W-1:0] velocity_four;
    logic signed [jap_pkg::VEL_W-1:0] velocity_five;
    logic signed [jap_pkg::VEL_W-1:0] velocity_six;
    logic reached;
    logic abort_flag;

    modport source (
        output valid, velocity_one, velocity_two, velocity_three, velocity_four,
               velocity_five, velocity_six, reached, abort_flag,
        input  ready
    );
    modport sink (
        input  valid, velocity_one, velocity_two, velocity_three, velocity_four,
               velocity_five, velocity_six, reached, abort_flag,
        output ready
    );
endinterface

FILE: design/jap_lane.sv
// One joint lane: target map, angle wrap of target and measurement, shortest
// error, tolerance checks and gain multiply in five stages. Depends on jap_pkg.
module jap_lane #(
    parameter int LANE            = 0,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                                   clk,
    input  logic signed [jap_pkg::ANGLE_W-1:0]     target,
    input  logic signed [jap_pkg::ANGLE_W-1:0]     measured,
    input  logic signed [jap_pkg::OFFSET_W-1:0]    offset,
    input  logic        [jap_pkg::TOL_W-1:0]       goal_tol,
    input  logic        [jap_pkg::TOL_W-1:0]       abort_tol,
    input  logic        [jap_pkg::GAIN_W-1:0]      gain,
    input  jap_pkg::pipe_ctrl_t                    ctrl,
    output jap_pkg::lane_res_t                     res
);

    localparam int F    = ANGLE_FRAC_BITS;
    localparam int AW   = F + 9;        // wrapped angle / error, signed
    localparam int MAGW = F + 8;        // error magnitude
    localparam int RW   = F + 10;       // remainder before final correction
    localparam int PW   = ((F + 8 > jap_pkg::ANGLE_W) ? F + 8 : jap_pkg::ANGLE_W) + 2;
    localparam int XW   = PW + 1;
    localparam int UW   = XW + 1;       // biased, non-negative angle
    localparam int CW   = (MAGW > jap_pkg::TOL_W) ? MAGW : jap_pkg::TOL_W;
    localparam int PVW  = AW + jap_pkg::GAIN_W + 1;

    localparam longint HALF = longint'(180) << F;
    localparam longint FULL = HALF * 2;
    localparam longint BASE = longint'(jap_pkg::JNT_QUARTER_BASE[LANE] ? 90 : 180) << F;
    localparam longint KOFF = ((longint'(1) << (XW - 1)) + FULL - 1) / FULL;
    localparam longint BIAS = HALF + KOFF * FULL;
    // floor(x / FULL) estimated as (x * RECIP) >> UW, low by at most one
    localparam longint RECIP = (longint'(1) << UW) / FULL;
    localparam int     MW    = $clog2(RECIP + 1);
    localparam int     PRW   = UW + MW;

    localparam bit ADD_TGT    = jap_pkg::JNT_ADD_TARGET[LANE];
    localparam bit USE_OFFSET = jap_pkg::JNT_USE_OFFSET[LANE];

    localparam logic signed [PW-1:0] BASE_S   = PW'(BASE);
    localparam logic signed [UW:0]   BIAS_S   = (UW + 1)'(BIAS);
    localparam logic [MW-1:0]        RECIP_U  = MW'(RECIP);
    localparam logic [UW-1:0]        FULL_U   = UW'(FULL);
    localparam logic [RW-1:0]        FULL_R   = RW'(FULL);
    localparam logic signed [RW:0]   HALF_R   = (RW + 1)'(HALF);
    localparam logic signed [AW:0]   HALF_D   = (AW + 1)'(HALF);
    localparam logic signed [AW:0]   FULL_D   = (AW + 1)'(FULL);

    // index 0 carries the target, index 1 the measurement
    logic [UW-1:0]         xo_reg   [2];
    logic [UW-1:0]         xo_next  [2];
    logic [PRW-1:0]        prod_reg [2];
    logic [PRW-1:0]        prod_next[2];
    logic [UW-1:0]         xo2_reg  [2];
    logic signed [AW-1:0]  ang_reg  [2];
    logic signed [AW-1:0]  ang_next [2];
    logic signed [AW-1:0]  err_reg;
    logic signed [AW-1:0]  err_next;
    logic                  move_reg;
    logic                  move_next;
    logic                  over_reg;
    logic                  over_next;
    jap_pkg::lane_res_t    res_reg;
    jap_pkg::lane_res_t    res_next;

    logic signed [PW-1:0]  base_val;
    logic signed [PW-1:0]  tgt_ext;
    logic signed [PW-1:0]  phys [2];
    logic signed [UW:0]    biased [2];
    logic [UW-1:0]         rem_full [2];
    logic [RW-1:0]         rem [2];
    logic [RW-1:0]         rem_c [2];
    logic signed [RW:0]    ang_w [2];
    logic signed [AW:0]    diff;
    logic signed [AW:0]    diff_adj;
    logic signed [AW:0]    mag_s;
    logic [MAGW-1:0]       mag;
    logic signed [PVW-1:0] prod_v;

    always_comb
    begin
        base_val = USE_OFFSET ? PW'(offset) : BASE_S;
        tgt_ext  = PW'(target);
        phys[0]  = ADD_TGT ? base_val + tgt_ext : base_val - tgt_ext;
        phys[1]  = PW'(measured);
        for (int i = 0; i < 2; i++)
        begin
            biased[i]    = (UW + 1)'(phys[i]) + BIAS_S;
            xo_next[i]   = biased[i][UW-1:0];
            prod_next[i] = PRW'(xo_reg[i]) * PRW'(RECIP_U);
            rem_full[i]  = xo2_reg[i] - UW'(prod_reg[i][UW +: MW]) * FULL_U;
            rem[i]       = rem_full[i][RW-1:0];
            rem_c[i]     = (rem[i] >= FULL_R) ? rem[i] - FULL_R : rem[i];
            ang_w[i]     = $signed({1'b0, rem_c[i]}) - HALF_R;
            ang_next[i]  = ang_w[i][AW-1:0];
        end
    end

    // shortest signed difference; an error of exactly a half turn is kept
    always_comb
    begin
        diff = (AW + 1)'(ang_reg[0]) - (AW + 1)'(ang_reg[1]);
        if (diff > HALF_D)
        begin
            diff_adj = diff - FULL_D;
        end
        else if (diff < -HALF_D)
        begin
            diff_adj = diff + FULL_D;
        end
        else
        begin
            diff_adj = diff;
        end
        err_next  = diff_adj[AW-1:0];
        mag_s     = (diff_adj < 0) ? -diff_adj : diff_adj;
        mag       = mag_s[MAGW-1:0];
        move_next = CW'(mag) > CW'(goal_tol);
        over_next = CW'(mag) > CW'(abort_tol);
    end

    always_comb
    begin
        prod_v        = $signed({1'b0, gain}) * err_reg;
        res_next.vel  = move_reg ? jap_pkg::VEL_W'(prod_v) : '0;
        res_next.move = move_reg;
        res_next.over = over_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (ctrl.en[jap_pkg::ST_MAP])
            begin
                xo_reg[i] <= xo_next[i];
            end
            if (ctrl.en[jap_pkg::ST_MUL])
            begin
                prod_reg[i] <= prod_next[i];
                xo2_reg[i]  <= xo_reg[i];
            end
            if (ctrl.en[jap_pkg::ST_WRAP])
            begin
                ang_reg[i] <= ang_next[i];
            end
        end
        if (ctrl.en[jap_pkg::ST_ERR])
        begin
            err_reg  <= err_next;
            move_reg <= move_next;
            over_reg <= over_next;
        end
        if (ctrl.en[jap_pkg::ST_VEL])
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: design/jap_merge.sv
// Merge stage: combines per-lane flags into reached / abort and holds the
// output register of the result channel. Depends on jap_pkg and jap_out_if.
module jap_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  jap_pkg::lane_res_t res [jap_pkg::NUM_JOINTS],
    input  logic               res_valid,
    output logic               space,
    jap_out_if.source          out_ch
);

    logic                             valid_reg;
    logic                             valid_next;
    logic signed [jap_pkg::VEL_W-1:0] vel_reg [jap_pkg::NUM_JOINTS];
    logic                             reached_reg;
    logic                             reached_next;
    logic                             abort_reg;
    logic                             abort_next;
    logic                             load;

    assign space = !valid_reg || out_ch.ready;
    assign load  = res_valid && space;

    always_comb
    begin
        reached_next = 1'b1;
        abort_next   = 1'b0;
        for (int j = 0; j < jap_pkg::NUM_JOINTS; j++)
        begin
            reached_next = reached_next & ~res[j].move;
            abort_next   = abort_next | (res[j].move & res[j].over);
        end
        valid_next = load || (valid_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int j = 0; j < jap_pkg::NUM_JOINTS; j++)
            begin
                vel_reg[j] <= res[j].vel;
            end
            reached_reg <= reached_next;
            abort_reg   <= abort_next;
        end
    end

    assign out_ch.valid          = valid_reg;
    assign out_ch.velocity_one   = vel_reg[0];
    assign out_ch.velocity_two   = vel_reg[1];
    assign out_ch.velocity_three = vel_reg[2];
    assign out_ch.velocity_four  = vel_reg[3];
    assign out_ch.velocity_five  = vel_reg[4];
    assign out_ch.velocity_six   = vel_reg[5];
    assign out_ch.reached        = reached_reg;
    assign out_ch.abort_flag     = abort_reg;

endmodule

FILE: design/joint_angle_p_controller.sv
// From input transfer to result valid, an item passes the five lane stages and
// then the output register. Throughput: one item per cycle while results are
// taken; each pipeline stage holds its item only while the stage after it is
// full, so input stays open while a result waits until all five lane stages
// hold items. Reset clears all stage valids and the output valid and loads the
// configuration registers with their defaults.
module joint_angle_p_controller #(
    parameter int JOINT_COUNT     = 6,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    jap_in_if.sink                            in_ch,
    jap_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [jap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jap_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int NST = jap_pkg::NUM_STAGES;

    logic signed [jap_pkg::OFFSET_W-1:0] offset_reg;
    logic signed [jap_pkg::OFFSET_W-1:0] offset_next;
    logic [jap_pkg::TOL_W-1:0]           goal_reg;
    logic [jap_pkg::TOL_W-1:0]           goal_next;
    logic [jap_pkg::TOL_W-1:0]           abort_reg;
    logic [jap_pkg::TOL_W-1:0]           abort_next;
    logic [jap_pkg::GAIN_W-1:0]          gain_reg;
    logic [jap_pkg::GAIN_W-1:0]          gain_next;

    logic [NST-1:0]      vld_reg;
    logic [NST-1:0]      vld_next;
    logic [NST:0]        rdy;
    jap_pkg::pipe_ctrl_t ctrl;
    logic                space;

    logic signed [jap_pkg::ANGLE_W-1:0] tgt  [jap_pkg::NUM_JOINTS];
    logic signed [jap_pkg::ANGLE_W-1:0] meas [jap_pkg::NUM_JOINTS];
    jap_pkg::lane_res_t                 res  [jap_pkg::NUM_JOINTS];

    // configuration write decode
    always_comb
    begin
        offset_next = offset_reg;
        goal_next   = goal_reg;
        abort_next  = abort_reg;
        gain_next   = gain_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                jap_pkg::CFG_OFFSET: offset_next = cfg_data[jap_pkg::OFFSET_W-1:0];
                jap_pkg::CFG_GOAL:   goal_next   = cfg_data[jap_pkg::TOL_W-1:0];
                jap_pkg::CFG_ABORT:  abort_next  = cfg_data[jap_pkg::TOL_W-1:0];
                jap_pkg::CFG_GAIN:   gain_next   = cfg_data[jap_pkg::GAIN_W-1:0];
            endcase
        end
    end

    // stage k takes a new item when it is empty or its item moves on
    always_comb
    begin
        rdy[NST] = space;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        ctrl.en[0] = in_ch.valid && rdy[0];
        for (int k = 1; k < NST; k++)
        begin
            ctrl.en[k] = vld_reg[k-1] && rdy[k];
        end
        vld_next = ctrl.en | (vld_reg & ~rdy[NST:1]);
    end

    assign in_ch.ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            offset_reg <= jap_pkg::OFFSET_RST;
            goal_reg   <= jap_pkg::GOAL_RST;
            abort_reg  <= jap_pkg::ABORT_RST;
            gain_reg   <= jap_pkg::GAIN_RST;
        end
        else
        begin
            vld_reg    <= vld_next;
            offset_reg <= offset_next;
            goal_reg   <= goal_next;
            abort_reg  <= abort_next;
            gain_reg   <= gain_next;
        end
    end

    assign tgt[0]  = in_ch.target_one;
    assign tgt[1]  = in_ch.target_two;
    assign tgt[2]  = in_ch.target_three;
    assign tgt[3]  = in_ch.target_four;
    assign tgt[4]  = in_ch.target_five;
    assign tgt[5]  = in_ch.target_six;
    assign meas[0] = in_ch.measured_one;
    assign meas[1] = in_ch.measured_two;
    assign meas[2] = in_ch.measured_three;
    assign meas[3] = in_ch.measured_four;
    assign meas[4] = in_ch.measured_five;
    assign meas[5] = in_ch.measured_six;

    for (genvar j = 0; j < jap_pkg::NUM_JOINTS; j++)
    begin : g_lane
        if (j < JOINT_COUNT)
        begin : g_on
            jap_lane #(
                .LANE            (j),
                .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
            ) u_lane (
                .clk       (clk),
                .target    (tgt[j]),
                .measured  (meas[j]),
                .offset    (offset_reg),
                .goal_tol  (goal_reg),
                .abort_tol (abort_reg),
                .gain      (gain_reg),
                .ctrl      (ctrl),
                .res       (res[j])
            );
        end
        else
        begin : g_off
            // unused joint: zero velocity, no effect on either flag
            assign res[j] = '0;
        end
    end

    jap_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_valid (vld_reg[NST-1]),
        .space     (space),
        .out_ch    (out_ch)
    );

endmodule

FILE: design/jap_checker.sv
// Port-level checks for joint_angle_p_controller, attached with a bind.
// Depends on jap_pkg and on the top level's channel interfaces.
module jap_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [jap_pkg::VEL_W-1:0]  vel_one,
    input logic signed [jap_pkg::VEL_W-1:0]  vel_two,
    input logic signed [jap_pkg::VEL_W-1:0]  vel_three,
    input logic signed [jap_pkg::VEL_W-1:0]  vel_four,
    input logic signed [jap_pkg::VEL_W-1:0]  vel_five,
    input logic signed [jap_pkg::VEL_W-1:0]  vel_six,
    input logic                              reached,
    input logic                              abort_flag
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(vel_one) && $stable(vel_six)
            && $stable(reached) && $stable(abort_flag))
        else $error("stalled result changed");

    // abort comes only from a moving joint, which also clears reached
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(reached && abort_flag))
        else $error("reached and abort both set");

    a_reached_still: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reached |-> vel_one == 0 && vel_two == 0 && vel_three == 0
            && vel_four == 0 && vel_five == 0 && vel_six == 0)
        else $error("nonzero velocity with reached set");

endmodule

bind joint_angle_p_controller jap_checker u_jap_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .vel_one    (out_ch.velocity_one),
    .vel_two    (out_ch.velocity_two),
    .vel_three  (out_ch.velocity_three),
    .vel_four   (out_ch.velocity_four),
    .vel_five   (out_ch.velocity_five),
    .vel_six    (out_ch.velocity_six),
    .reached    (out_ch.reached),
    .abort_flag (out_ch.abort_flag)
);

FILE: bench/jap_bench_pkg.sv
// Bench-side types and the command tracker for the joint angle P controller:
// predicts one command per accepted sample and checks the returned commands.
// Depends on jap_pkg for field widths and register indexes.
`timescale 1ns / 100ps

package jap_bench_pkg;

    localparam longint FRAC_ONE  = 256;
    localparam longint HALF_TURN = 180 * FRAC_ONE;
    localparam longint FULL_TURN = 360 * FRAC_ONE;
    localparam longint ANGLE_LO  = -2 * FULL_TURN;
    localparam longint ANGLE_HI  = 2 * FULL_TURN - 1;

    typedef logic signed [jap_pkg::ANGLE_W-1:0] angle_t;
    typedef logic signed [jap_pkg::VEL_W-1:0]   vel_t;

    typedef struct {
        angle_t target[jap_pkg::NUM_JOINTS];
        angle_t measured[jap_pkg::NUM_JOINTS];
    } joint_sample_t;

    typedef struct {
        vel_t velocity[jap_pkg::NUM_JOINTS];
        logic reached;
        logic abort_flag;
    } joint_command_t;

    class command_tracker;
        logic signed [jap_pkg::OFFSET_W-1:0] offset;
        logic [jap_pkg::TOL_W-1:0]           goal_tol;
        logic [jap_pkg::TOL_W-1:0]           abort_tol;
        logic [jap_pkg::GAIN_W-1:0]          gain;
        joint_command_t                      expected_cmds[$];
        int                                  mismatches;
        int                                  checked;
        string                               vel_names[jap_pkg::NUM_JOINTS];

        function new();
            offset     = jap_pkg::OFFSET_RST;
            goal_tol   = jap_pkg::GOAL_RST;
            abort_tol  = jap_pkg::ABORT_RST;
            gain       = jap_pkg::GAIN_RST;
            mismatches = 0;
            checked    = 0;
            vel_names  = '{"velocity_one", "velocity_two", "velocity_three",
                           "velocity_four", "velocity_five", "velocity_six"};
        endfunction

        function void write_reg(logic [jap_pkg::CFG_IDX_W-1:0] index,
                                logic [jap_pkg::CFG_DATA_W-1:0] data);
            case (index)
                jap_pkg::CFG_OFFSET: offset    = data[jap_pkg::OFFSET_W-1:0];
                jap_pkg::CFG_GOAL:   goal_tol  = data[jap_pkg::TOL_W-1:0];
                jap_pkg::CFG_ABORT:  abort_tol = data[jap_pkg::TOL_W-1:0];
                jap_pkg::CFG_GAIN:   gain      = data[jap_pkg::GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // floor modulo into [-180,180)
        function longint wrap_deg(longint a);
            longint r;
            r = (a + HALF_TURN) % FULL_TURN;
            if (r < 0)
                r += FULL_TURN;
            return r - HALF_TURN;
        endfunction

        function longint physical_target(int j, longint a);
            case (j)
                1:       return longint'(offset) + a;
                2:       return HALF_TURN / 2 - a;
                5:       return longint'(offset) - a;
                default: return HALF_TURN - a;
            endcase
        endfunction

        function joint_command_t predict_command(joint_sample_t s);
            joint_command_t c;
            longint t;
            longint m;
            longint e;
            longint mag;
            longint v;
            c.reached    = 1'b1;
            c.abort_flag = 1'b0;
            for (int j = 0; j < jap_pkg::NUM_JOINTS; j++)
            begin
                t = wrap_deg(physical_target(j, longint'(s.target[j])));
                m = wrap_deg(longint'(s.measured[j]));
                e = t - m;
                // exactly a half turn either way is kept as it is
                if (e > HALF_TURN)
                    e -= FULL_TURN;
                else if (e < -HALF_TURN)
                    e += FULL_TURN;
                mag = (e < 0) ? -e : e;
                v = 0;
                if (mag > longint'(goal_tol))
                begin
                    // abort only counts for joints that still move
                    if (mag > longint'(abort_tol))
                        c.abort_flag = 1'b1;
                    c.reached = 1'b0;
                    v = longint'(gain) * e;
                end
                c.velocity[j] = v[jap_pkg::VEL_W-1:0];
            end
            return c;
        endfunction

        function void note_sample(joint_sample_t s);
            expected_cmds.push_back(predict_command(s));
        endfunction

        function void check_command(joint_command_t got);
            joint_command_t want;
            if (expected_cmds.size() == 0)
            begin
                $error("command transfer with no sample outstanding");
                mismatches++;
                return;
            end
            want = expected_cmds.pop_front();
            checked++;
            for (int j = 0; j < jap_pkg::NUM_JOINTS; j++)
            begin
                if (got.velocity[j] !== want.velocity[j])
                begin
                    $error("%s: expected %0d, got %0d", vel_names[j],
                           want.velocity[j], got.velocity[j]);
                    mismatches++;
                end
            end
            if (got.reached !== want.reached)
            begin
                $error("reached: expected %0d, got %0d", want.reached, got.reached);
                mismatches++;
            end
            if (got.abort_flag !== want.abort_flag)
            begin
                $error("abort_flag: expected %0d, got %0d", want.abort_flag, got.abort_flag);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction
    endclass

endpackage

FILE: bench/tb_joint_angle_p_controller.sv
// Top-level bench for joint_angle_p_controller: directed edge cases, then random
// samples over several register settings, with random gaps on both channels.
// Depends on jap_pkg, jap_if and jap_bench_pkg.
`timescale 1ns / 100ps

module tb_joint_angle_p_controller;

    localparam int CMD_LATENCY   = 6;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_SAMPLES = 190;

    localparam longint HALF_TURN = jap_bench_pkg::HALF_TURN;
    localparam longint FULL_TURN = jap_bench_pkg::FULL_TURN;
    localparam longint ANGLE_LO  = jap_bench_pkg::ANGLE_LO;
    localparam longint ANGLE_HI  = jap_bench_pkg::ANGLE_HI;
    localparam int     ANGLE_W   = jap_pkg::ANGLE_W;
    localparam int     DATA_W    = jap_pkg::CFG_DATA_W;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [jap_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [jap_pkg::CFG_DATA_W-1:0] cfg_data;
    logic calm = 1'b0;

    int samples_sent = 0;
    int settings_used = 1;

    jap_bench_pkg::command_tracker tracker = new();

    jap_in_if  in_ch();
    jap_out_if out_ch();

    joint_angle_p_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint rand_between(longint lo, longint hi);
        return lo + longint'($urandom_range(0, int'(hi - lo)));
    endfunction

    // DH target that yields physical error delta against measured m
    function automatic jap_bench_pkg::angle_t dh_for_error(int j, longint m, longint delta);
        longint p;
        longint a;
        longint off;
        p = m + delta;
        off = longint'(tracker.offset);
        case (j)
            1:       a = p - off;
            2:       a = HALF_TURN / 2 - p;
            5:       a = off - p;
            default: a = HALF_TURN - p;
        endcase
        while (a > ANGLE_HI)
            a -= FULL_TURN;
        while (a < ANGLE_LO)
            a += FULL_TURN;
        return a[ANGLE_W-1:0];
    endfunction

    function automatic jap_bench_pkg::joint_sample_t sample_with_error(longint m,
                                                                       longint delta);
        jap_bench_pkg::joint_sample_t s;
        for (int j = 0; j < jap_pkg::NUM_JOINTS; j++)
        begin
            s.measured[j] = m[ANGLE_W-1:0];
            s.target[j]   = dh_for_error(j, m, delta);
        end
        return s;
    endfunction

    function automatic jap_bench_pkg::joint_sample_t sample_fill(longint t, longint m);
        jap_bench_pkg::joint_sample_t s;
        for (int j = 0; j < jap_pkg::NUM_JOINTS; j++)
        begin
            s.target[j]   = t[ANGLE_W-1:0];
            s.measured[j] = m[ANGLE_W-1:0];
        end
        return s;
    endfunction

    function automatic jap_bench_pkg::joint_sample_t random_sample();
        jap_bench_pkg::joint_sample_t s;
        longint edges[9];
        longint m;
        longint delta;
        int kind;
        edges = '{ANGLE_LO, ANGLE_HI, -HALF_TURN, HALF_TURN, 0,
                  -FULL_TURN, FULL_TURN, -1, 1};
        for (int j = 0; j < jap_pkg::NUM_JOINTS; j++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
            begin
                m = rand_between(ANGLE_LO, ANGLE_HI);
                case ($urandom_range(0, 3))
                    0:       delta = longint'(tracker.goal_tol)
                                     + longint'($urandom_range(0, 4)) - 2;
                    1:       delta = longint'(tracker.abort_tol)
                                     + longint'($urandom_range(0, 4)) - 2;
                    2:       delta = longint'($urandom_range(0, int'(HALF_TURN)));
                    default: delta = HALF_TURN + longint'($urandom_range(0, 4)) - 2;
                endcase
                if ($urandom_range(0, 1))
                    delta = -delta;
                s.measured[j] = m[ANGLE_W-1:0];
                s.target[j]   = dh_for_error(j, m, delta);
            end
            else if (kind < 8)
            begin
                s.target[j]   = jap_bench_pkg::angle_t'(rand_between(ANGLE_LO, ANGLE_HI));
                s.measured[j] = jap_bench_pkg::angle_t'(rand_between(ANGLE_LO, ANGLE_HI));
            end
            else if (kind == 8)
            begin
                // any bit pattern, outside the stated range too
                s.target[j]   = jap_bench_pkg::angle_t'($urandom());
                s.measured[j] = jap_bench_pkg::angle_t'($urandom());
            end
            else
            begin
                s.target[j]   = jap_bench_pkg::angle_t'(edges[$urandom_range(0, 8)]);
                s.measured[j] = jap_bench_pkg::angle_t'(edges[$urandom_range(0, 8)]);
            end
        end
        return s;
    endfunction

    // call it just after the clock rises; it returns just after the sample is accepted
    task automatic send_sample(input jap_bench_pkg::joint_sample_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.target_one     <= s.target[0];
        in_ch.target_two     <= s.target[1];
        in_ch.target_three   <= s.target[2];
        in_ch.target_four    <= s.target[3];
        in_ch.target_five    <= s.target[4];
        in_ch.target_six     <= s.target[5];
        in_ch.measured_one   <= s.measured[0];
        in_ch.measured_two   <= s.measured[1];
        in_ch.measured_three <= s.measured[2];
        in_ch.measured_four  <= s.measured[3];
        in_ch.measured_five  <= s.measured[4];
        in_ch.measured_six   <= s.measured[5];
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        tracker.note_sample(s);
        samples_sent++;
    endtask

    // writes all four registers in turn; block must be idle
    task automatic set_config(input longint off, input longint goal,
                              input longint abrt, input longint gn);
        cfg_we    <= 1'b1;
        cfg_index <= jap_pkg::CFG_OFFSET;
        cfg_data  <= off[DATA_W-1:0];
        tracker.write_reg(jap_pkg::CFG_OFFSET, off[DATA_W-1:0]);
        @(posedge clk);
        cfg_index <= jap_pkg::CFG_GOAL;
        cfg_data  <= goal[DATA_W-1:0];
        tracker.write_reg(jap_pkg::CFG_GOAL, goal[DATA_W-1:0]);
        @(posedge clk);
        cfg_index <= jap_pkg::CFG_ABORT;
        cfg_data  <= abrt[DATA_W-1:0];
        tracker.write_reg(jap_pkg::CFG_ABORT, abrt[DATA_W-1:0]);
        @(posedge clk);
        cfg_index <= jap_pkg::CFG_GAIN;
        cfg_data  <= gn[DATA_W-1:0];
        tracker.write_reg(jap_pkg::CFG_GAIN, gn[DATA_W-1:0]);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (CMD_LATENCY + 4) @(posedge clk);
    endtask

    // result side: check each transfer, then pick the next ready level
    initial
    begin
        jap_bench_pkg::joint_command_t got;
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got.velocity[0] = out_ch.velocity_one;
                got.velocity[1] = out_ch.velocity_two;
                got.velocity[2] = out_ch.velocity_three;
                got.velocity[3] = out_ch.velocity_four;
                got.velocity[4] = out_ch.velocity_five;
                got.velocity[5] = out_ch.velocity_six;
                got.reached     = out_ch.reached;
                got.abort_flag  = out_ch.abort_flag;
                tracker.check_command(got);
            end
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        longint goal;
        longint abrt;
        longint off;
        longint gn;
        rst_n = 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.target_one     <= '0;
        in_ch.target_two     <= '0;
        in_ch.target_three   <= '0;
        in_ch.target_four    <= '0;
        in_ch.target_five    <= '0;
        in_ch.target_six     <= '0;
        in_ch.measured_one   <= '0;
        in_ch.measured_two   <= '0;
        in_ch.measured_three <= '0;
        in_ch.measured_four  <= '0;
        in_ch.measured_five  <= '0;
        in_ch.measured_six   <= '0;
        out_ch.ready         <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= jap_pkg::CFG_OFFSET;
        cfg_data             <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: field extremes, wrap points, tolerance edges
        send_sample(sample_fill(0, 0));
        send_sample(sample_fill(ANGLE_LO, ANGLE_LO));
        send_sample(sample_fill(ANGLE_HI, ANGLE_HI));
        send_sample(sample_fill(0, HALF_TURN));
        send_sample(sample_with_error(-HALF_TURN, HALF_TURN));
        send_sample(sample_with_error(0, -HALF_TURN));
        send_sample(sample_with_error(0, HALF_TURN + 1));
        send_sample(sample_with_error(1000, 256));
        send_sample(sample_with_error(1000, -256));
        send_sample(sample_with_error(1000, 257));
        send_sample(sample_with_error(-5000, -257));
        send_sample(sample_with_error(0, 10240));
        send_sample(sample_with_error(0, -10241));
        send_sample(sample_fill(-262144, -262144));
        send_sample(sample_fill(262143, 262143));
        drain();

        // widest goal, zero abort, top gain and offset
        set_config(92159, 46080, 0, 15);
        send_sample(sample_with_error(0, HALF_TURN));
        send_sample(sample_with_error(0, -HALF_TURN + 1));
        send_sample(sample_with_error(0, -HALF_TURN));
        drain();

        // zero goal and gain: joints move at zero speed
        set_config(-92160, 0, 46080, 0);
        send_sample(sample_with_error(7, 1));
        send_sample(sample_with_error(7, -1));
        send_sample(sample_with_error(0, HALF_TURN));
        drain();

        // abort below goal: a joint within goal never aborts
        set_config(300, 2000, 100, 1);
        send_sample(sample_with_error(0, 1000));
        send_sample(sample_with_error(0, 2001));
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 9))
                0, 1:    off = $urandom_range(0, 1) ? longint'(-92160) : longint'(92159);
                2:       off = longint'($urandom());
                default: off = rand_between(-92160, 92159);
            endcase
            case ($urandom_range(0, 9))
                0:       goal = $urandom_range(0, 1) ? longint'(0) : longint'(46080);
                1:       goal = longint'($urandom_range(0, 262143));
                2, 3:    goal = longint'($urandom_range(0, 46080));
                default: goal = longint'($urandom_range(0, 1024));
            endcase
            case ($urandom_range(0, 9))
                0:       abrt = $urandom_range(0, 1) ? longint'(0) : longint'(46080);
                1:       abrt = longint'($urandom_range(0, 262143));
                default: abrt = longint'($urandom_range(0, 46080));
            endcase
            if (ph == 0)
                gn = 15;
            else if (ph == 1)
                gn = 0;
            else
                gn = longint'($urandom_range(0, 15));
            if ($urandom_range(0, 4) == 0)
                gn = gn | (longint'($urandom_range(0, 16383)) << jap_pkg::GAIN_W);
            set_config(off, goal, abrt, gn);
            calm = (ph % 4 == 2);
            repeat (PHASE_SAMPLES) send_sample(random_sample());
            drain();
        end
        calm = 1'b0;

        $display("Sent %0d samples under %0d register settings, %0d commands checked.",
                 samples_sent, settings_used, tracker.checked);
        if (tracker.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $error("run did not complete in time, %0d commands outstanding", tracker.pending());
        $display("Mismatches found");
        $finish;
    end

endmodule
